// File: design/gmd_pkg.sv
// Package for the gRPC message deframer: status codes, framing constants,
// and the result record. No dependencies.
package gmd_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK          = 2'd0;
   localparam status_type STATUS_COMPRESSED  = 2'd1;
   localparam status_type STATUS_BAD_TAG     = 2'd2;
   localparam status_type STATUS_VARINT_LONG = 2'd3;

   localparam int         FIELD_HEADER_MAX = 6;
   localparam logic [7:0] FIELD_TAG        = 8'h0A;
   localparam logic [2:0] HDR_LAST_INDEX   = 3'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      status_type status;
   } result_type;

endpackage

// File: design/gmd_req_if.sv
// Request channel of the deframer: one stream byte per request.
// Depends on nothing.
interface gmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// File: design/gmd_rsp_if.sv
// Response channel of the deframer: payload byte, its flag and the status.
// Depends on gmd_pkg for the status type.
interface gmd_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   logic               out_valid;
   gmd_pkg::status_type status;

   modport source (output valid, output out_byte, output out_valid, output status,
                   input ready);
   modport sink (input valid, input out_byte, input out_valid, input status,
                 output ready);
endinterface

// File: design/gmd_parser.sv
// Framing state of the deframer and the single-step update for one byte.
// Depends on gmd_pkg.
module gmd_parser #(
   parameter int FieldHeaderMax = gmd_pkg::FIELD_HEADER_MAX
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   output gmd_pkg::result_type  result
);
   localparam int CountWidth = $clog2(FieldHeaderMax + 1);

   logic [31:0]           msg_rem_ff, msg_rem_in;
   logic [2:0]            hdr_count_ff, hdr_count_in;
   logic [31:0]           hdr_bytes_ff, hdr_bytes_in;
   logic [CountWidth-1:0] vcount_ff, vcount_in;
   logic [31:0]           vvalue_ff, vvalue_in;
   logic [31:0]           field_rem_ff, field_rem_in;
   gmd_pkg::status_type   error_ff, error_in;

   logic [2:0]  vcount_ext;
   logic [31:0] vbits;
   logic [31:0] vvalue_acc;

   assign vcount_ext = 3'(vcount_ff);

   always_comb begin
      case (vcount_ext)
         3'd1: vbits = {25'd0, in_byte[6:0]};
         3'd2: vbits = {18'd0, in_byte[6:0], 7'd0};
         3'd3: vbits = {11'd0, in_byte[6:0], 14'd0};
         3'd4: vbits = {4'd0, in_byte[6:0], 21'd0};
         3'd5: vbits = {in_byte[3:0], 28'd0};
         default: vbits = 32'd0;
      endcase
   end

   assign vvalue_acc = vvalue_ff | vbits;

   always_comb begin
      msg_rem_in   = msg_rem_ff;
      hdr_count_in = hdr_count_ff;
      hdr_bytes_in = hdr_bytes_ff;
      vcount_in    = vcount_ff;
      vvalue_in    = vvalue_ff;
      field_rem_in = field_rem_ff;
      error_in     = error_ff;
      result.out_byte  = 8'd0;
      result.out_valid = 1'b0;
      if (error_ff == gmd_pkg::STATUS_OK) begin
         if (msg_rem_ff == 32'd0) begin
            hdr_bytes_in = {hdr_bytes_ff[23:0], in_byte};
            hdr_count_in = hdr_count_ff + 3'd1;
            if (hdr_count_ff == gmd_pkg::HDR_LAST_INDEX) begin
               if (hdr_bytes_ff[31:24] != 8'd0) begin
                  error_in = gmd_pkg::STATUS_COMPRESSED;
               end else begin
                  msg_rem_in   = {hdr_bytes_ff[23:0], in_byte};
                  hdr_count_in = 3'd0;
                  vcount_in    = '0;
                  vvalue_in    = 32'd0;
                  field_rem_in = 32'd0;
               end
            end
         end else if (field_rem_ff == 32'd0) begin
            msg_rem_in = msg_rem_ff - 32'd1;
            if (vcount_ff >= CountWidth'(FieldHeaderMax)) begin
               error_in = gmd_pkg::STATUS_VARINT_LONG;
            end else if (vcount_ff == '0 && in_byte != gmd_pkg::FIELD_TAG) begin
               error_in = gmd_pkg::STATUS_BAD_TAG;
            end else begin
               vvalue_in = vvalue_acc;
               vcount_in = vcount_ff + CountWidth'(1);
               if (vcount_ff != '0 && !in_byte[7]) begin
                  field_rem_in = vvalue_acc;
                  vcount_in    = '0;
                  vvalue_in    = 32'd0;
               end
            end
         end else begin
            result.out_byte  = in_byte;
            result.out_valid = 1'b1;
            field_rem_in     = field_rem_ff - 32'd1;
            msg_rem_in       = msg_rem_ff - 32'd1;
         end
      end
      result.status = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_rem_ff   <= 32'd0;
         hdr_count_ff <= 3'd0;
         hdr_bytes_ff <= 32'd0;
         vcount_ff    <= '0;
         vvalue_ff    <= 32'd0;
         field_rem_ff <= 32'd0;
         error_ff     <= gmd_pkg::STATUS_OK;
      end else if (step) begin
         msg_rem_ff   <= msg_rem_in;
         hdr_count_ff <= hdr_count_in;
         hdr_bytes_ff <= hdr_bytes_in;
         vcount_ff    <= vcount_in;
         vvalue_ff    <= vvalue_in;
         field_rem_ff <= field_rem_in;
         error_ff     <= error_in;
      end
   end

endmodule

// File: design/grpc_message_deframer_unit.sv
// Top level of the gRPC message deframer: input register, parser step and
// result register. Depends on gmd_pkg, gmd_req_if, gmd_rsp_if and gmd_parser.
// A request's byte is held in the input register, passes through the parser step into the
// result register and is then offered on the response port, and one request is accepted
// every cycle while the response side keeps up.
// The parser advances once per byte as it moves from the input register to
// the result register. Synchronous reset clears all framing state and errors.
module grpc_message_deframer_unit #(
   parameter int FieldHeaderMax = gmd_pkg::FIELD_HEADER_MAX
) (
   input logic       clock,
   input logic       reset,
   gmd_req_if.sink   req_port,
   gmd_rsp_if.source rsp_port
);
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   gmd_pkg::result_type rsp_result_ff;
   gmd_pkg::result_type step_result;
   logic                s2_ready;
   logic                s2_take;
   logic                req_accept;

   assign s2_ready   = !rsp_valid_ff || rsp_port.ready;
   assign s2_take    = s1_valid_ff && s2_ready;
   assign req_port.ready = !s1_valid_ff || s2_take;
   assign req_accept = req_port.valid && req_port.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_take);
   assign rsp_valid_in = s2_take || (rsp_valid_ff && !rsp_port.ready);

   gmd_parser #(
      .FieldHeaderMax(FieldHeaderMax)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (s2_take),
      .in_byte (s1_byte_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_port.in_byte;
      end
      if (s2_take) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.out_byte  = rsp_result_ff.out_byte;
   assign rsp_port.out_valid = rsp_result_ff.out_valid;
   assign rsp_port.status    = rsp_result_ff.status;

endmodule

// File: design/gmd_checker.sv
// Port-level checks for the gRPC message deframer, attached by bind.
// Depends on gmd_pkg and grpc_message_deframer_unit.
module gmd_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [7:0]          rsp_out_byte,
   input logic                rsp_out_valid,
   input gmd_pkg::status_type rsp_status
);

   // An error, once reported, is repeated by every later response.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_status != gmd_pkg::STATUS_OK) ##1 rsp_valid
      |-> rsp_status == $past(rsp_status, 1))
      else $error("sticky error status changed");

   // Payload data is only passed while no error is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == gmd_pkg::STATUS_OK)
      else $error("payload byte reported together with an error");

   // A response without payload carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == 8'd0)
      else $error("non-payload response carries a nonzero byte");

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

endmodule

bind grpc_message_deframer_unit gmd_checker u_gmd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_out_byte  (rsp_port.out_byte),
   .rsp_out_valid (rsp_port.out_valid),
   .rsp_status    (rsp_port.status)
);

// File: bench/grpc_message_deframer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for grpc_message_deframer_unit: directed frames, random gRPC messages,
// then one closing sticky error. Depends on gmd_pkg, gmd_req_if, gmd_rsp_if and the unit.
module grpc_message_deframer_unit_tb;

   localparam int RANDOM_BYTES   = 400;
   localparam int CALM_FROM      = 320;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int PRINT_LIMIT    = 100;

   typedef struct packed {
      logic [7:0]          in_byte;
      logic                typed;
      gmd_pkg::result_type want;
   } stim_row_type;

   localparam stim_row_type [0:24] LEAD_TABLE = {
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h08, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h0A, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h01, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'hFF, 1'b1, gmd_pkg::STATUS_OK},
      {8'h0A, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h0A, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h02, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b1, gmd_pkg::STATUS_OK},
      {8'h00, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h02, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h0A, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h85, 1'b0, 8'h00, 1'b0, gmd_pkg::STATUS_OK}
   };

   localparam stim_row_type [0:6] COMPRESSED_TAIL = {
      {8'h01, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_COMPRESSED},
      {8'h0A, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_COMPRESSED},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_COMPRESSED}
   };

   localparam stim_row_type [0:7] BAD_TAG_TAIL = {
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h0B, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_BAD_TAG},
      {8'h0A, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_BAD_TAG},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_BAD_TAG}
   };

   localparam stim_row_type [0:13] VARINT_LONG_TAIL = {
      {8'h00, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h0A, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h80, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h80, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h80, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h80, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h80, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_OK},
      {8'h7F, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_VARINT_LONG},
      {8'h0A, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_VARINT_LONG},
      {8'hFF, 1'b1, 8'h00, 1'b0, gmd_pkg::STATUS_VARINT_LONG}
   };

   logic clock = 1'b0;
   logic reset;

   gmd_req_if req_port();
   gmd_rsp_if rsp_port();

   grpc_message_deframer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

   always #5 clock = ~clock;

   logic [31:0]         body_left;
   logic [2:0]          hdr_taken;
   logic [39:0]         hdr_shift;
   logic [2:0]          len_bytes;
   logic [31:0]         len_accum;
   logic [31:0]         data_left;
   gmd_pkg::status_type sticky_status;

   gmd_pkg::result_type expected_results[$];
   gmd_pkg::result_type oldest_result;
   stim_row_type        table_rows[$];
   logic [7:0]          stream_q[$];

   int                  requests_sent;
   int                  results_checked;
   int                  payload_bytes;
   int                  mismatch_count;
   int                  quiet_cycles;
   int                  stall_left;
   int                  random_bytes;
   bit                  src_gaps_on;
   bit                  dst_stalls_on;
   bit                  calm;
   gmd_pkg::status_type closing_error;

   function automatic gmd_pkg::result_type deframe_byte(input logic [7:0] b);
      gmd_pkg::result_type r;
      logic [63:0]         wide;
      int                  shift;
      r = '0;
      if (sticky_status == gmd_pkg::STATUS_OK) begin
         if (body_left == 32'd0) begin
            hdr_shift = {hdr_shift[31:0], b};
            hdr_taken = hdr_taken + 3'd1;
            if (hdr_taken > gmd_pkg::HDR_LAST_INDEX) begin
               if (hdr_shift[39:32] != 8'h00) begin
                  sticky_status = gmd_pkg::STATUS_COMPRESSED;
               end else begin
                  body_left = hdr_shift[31:0];
                  hdr_taken = '0;
                  len_bytes = '0;
                  len_accum = '0;
                  data_left = '0;
               end
            end
         end else if (data_left == 32'd0) begin
            body_left = body_left - 32'd1;
            if (len_bytes >= gmd_pkg::FIELD_HEADER_MAX) begin
               sticky_status = gmd_pkg::STATUS_VARINT_LONG;
            end else if (len_bytes == 3'd0 && b != gmd_pkg::FIELD_TAG) begin
               sticky_status = gmd_pkg::STATUS_BAD_TAG;
            end else begin
               if (len_bytes >= 3'd1) begin
                  shift = 7 * (len_bytes - 1);
                  if (shift < 32) begin
                     wide = {57'd0, b[6:0]} << shift;
                     len_accum = len_accum | wide[31:0];
                  end
               end
               len_bytes = len_bytes + 3'd1;
               if (len_bytes > 3'd1 && !b[7]) begin
                  data_left = len_accum;
                  len_bytes = '0;
                  len_accum = '0;
               end
            end
         end else begin
            r.out_byte  = b;
            r.out_valid = 1'b1;
            data_left   = data_left - 32'd1;
            body_left   = body_left - 32'd1;
         end
      end
      r.status = sticky_status;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch on result %0d: %s got %0h want %0h",
                  results_checked, what, got, want);
   endtask

   task automatic send_request(input logic [7:0] b, input logic typed,
                               input gmd_pkg::result_type want);
      gmd_pkg::result_type predicted;
      if (src_gaps_on && !calm && $urandom_range(0, 5) == 0) begin
         req_port.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_port.valid   <= 1'b1;
      req_port.in_byte <= b;
      do @(posedge clock); while (!req_port.ready);
      predicted = deframe_byte(b);
      expected_results.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   task automatic walk_table();
      for (int i = 0; i < table_rows.size(); i++)
         send_request(table_rows[i].in_byte, table_rows[i].typed, table_rows[i].want);
   endtask

   // One message into stream_q: fields with random data, sometimes padded or oversized
   // length prefixes, and sometimes a message length that cuts the body short.
   task automatic build_message();
      logic [7:0]  body_q[$];
      logic [31:0] field_len;
      logic [31:0] msg_len;
      logic [34:0] rest;
      logic [7:0]  vbyte;
      int          n_fields, min_width, width, n_data;
      bit          huge;
      huge = 1'b0;
      stream_q = {};
      n_fields = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      for (int f = 0; f < n_fields && !huge; f++) begin
         huge = ($urandom_range(0, 7) == 0);
         if (huge) begin
            field_len = $urandom;
            if (field_len < 32'h1000_0000) field_len = field_len + 32'h1000_0000;
         end else begin
            field_len = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 12);
         end
         body_q.push_back(gmd_pkg::FIELD_TAG);
         min_width = 1;
         while (min_width < 5 && (field_len >> (7 * min_width)) != 0) min_width++;
         width = ($urandom_range(0, 4) == 0) ? $urandom_range(min_width, 5) : min_width;
         rest = {3'b000, field_len};
         for (int k = 0; k < width; k++) begin
            vbyte = {k < width - 1, rest[6:0]};
            if (k == 4) vbyte[6:4] = 3'($urandom_range(0, 7));
            body_q.push_back(vbyte);
            rest = rest >> 7;
         end
         n_data = huge ? $urandom_range(0, 8) : field_len;
         for (int k = 0; k < n_data; k++) body_q.push_back(8'($urandom_range(0, 255)));
      end
      msg_len = body_q.size();
      if (!huge && msg_len > 0 && $urandom_range(0, 3) == 0)
         msg_len = $urandom_range(0, body_q.size() - 1);
      stream_q.push_back(8'h00);
      stream_q.push_back(msg_len[31:24]);
      stream_q.push_back(msg_len[23:16]);
      stream_q.push_back(msg_len[15:8]);
      stream_q.push_back(msg_len[7:0]);
      for (int k = 0; k < msg_len; k++) stream_q.push_back(body_q[k]);
   endtask

   initial begin
      rsp_port.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_port.ready <= 1'b0;
         end else if (dst_stalls_on && !calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_port.ready <= 1'b0;
         end else begin
            rsp_port.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_port.out_byte, 8'h00);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_port.out_byte !== oldest_result.out_byte)
               report_mismatch("out_byte", rsp_port.out_byte, oldest_result.out_byte);
            if (rsp_port.out_valid !== oldest_result.out_valid)
               report_mismatch("out_valid", rsp_port.out_valid, oldest_result.out_valid);
            if (rsp_port.status !== oldest_result.status)
               report_mismatch("status", rsp_port.status, oldest_result.status);
            if (oldest_result.out_valid) payload_bytes++;
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_port.valid   = 1'b0;
      req_port.in_byte = 8'h00;
      body_left        = '0;
      hdr_taken        = '0;
      hdr_shift        = '0;
      len_bytes        = '0;
      len_accum        = '0;
      data_left        = '0;
      sticky_status    = gmd_pkg::STATUS_OK;
      src_gaps_on      = 1'b1;
      dst_stalls_on    = 1'b1;
      calm             = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(LEAD_TABLE); i++) table_rows.push_back(LEAD_TABLE[i]);
      walk_table();

      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         src_gaps_on   = ($urandom_range(0, 2) != 0);
         dst_stalls_on = ($urandom_range(0, 2) != 0);
         calm          = (random_bytes >= CALM_FROM);
         build_message();
         foreach (stream_q[i]) send_request(stream_q[i], 1'b0, '0);
         random_bytes += stream_q.size();
      end

      // The error is sticky until reset, so only one kind can close the run.
      closing_error = gmd_pkg::status_type'($urandom_range(1, 3));
      table_rows = {};
      case (closing_error)
         gmd_pkg::STATUS_COMPRESSED: begin
            for (int i = 0; i < $size(COMPRESSED_TAIL); i++)
               table_rows.push_back(COMPRESSED_TAIL[i]);
         end
         gmd_pkg::STATUS_BAD_TAG: begin
            for (int i = 0; i < $size(BAD_TAG_TAIL); i++)
               table_rows.push_back(BAD_TAG_TAIL[i]);
         end
         default: begin
            for (int i = 0; i < $size(VARINT_LONG_TAIL); i++)
               table_rows.push_back(VARINT_LONG_TAIL[i]);
         end
      endcase
      walk_table();
      req_port.valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d stream bytes sent, %0d results checked, %0d payload bytes",
               requests_sent, results_checked, payload_bytes);
      $display("summary: run closed on sticky status code %0d, %0d mismatches",
               closing_error, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
